// ===== sv/qrbd_pkg.sv =====
// Package: shared types and constants for the crate readout block decoder.
`timescale 1ns / 1ps
`default_nettype none
package qrbd_pkg;

  localparam int unsigned NUM_BOARDS    = 16;
  localparam int unsigned NUM_TIME_BINS = 8;

  localparam logic [31:0] TRAILER_WORD = 32'h0000_ac10;
  localparam logic [3:0]  ADDR_HIGH_NIB = 4'h1;  // board addresses 0x10..0x1F

  localparam logic [2:0] ST_HEADER      = 3'd0;
  localparam logic [2:0] ST_VALUE       = 3'd1;
  localparam logic [2:0] ST_TRAILER_OK  = 3'd2;
  localparam logic [2:0] ST_CRATE       = 3'd3;
  localparam logic [2:0] ST_ADDR        = 3'd4;
  localparam logic [2:0] ST_BAD_TRAILER = 3'd5;
  localparam logic [2:0] ST_TRUNC       = 3'd6;
  localparam logic [2:0] ST_SKIP        = 3'd7;

  // Word after classification, independent of decoder state
  typedef struct packed {
    logic        is_last;
    logic        trailer_ok;
    logic        crate_ok;
    logic        addr_ok;
    logic [3:0]  board;
    logic [7:0]  lines;
    logic [4:0]  chan;
    logic [11:0] value;
    logic [2:0]  bin;
  } cls_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  board_index;
    logic [4:0]  channel;
    logic [2:0]  bin_out;
    logic [11:0] value;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/qrbd_fifo.sv =====
// Small synchronous queue with registered count and pointers.
`timescale 1ns / 1ps
`default_nettype none
module qrbd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output logic      [WIDTH-1:0] dout
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

// ===== sv/qrbd_front.sv =====
// Front end: splits an incoming word into fields and stateless checks.
`timescale 1ns / 1ps
`default_nettype none
module qrbd_front
  import qrbd_pkg::*;
(
  input  wire logic [31:0] word,
  input  wire logic        last_word,
  input  wire logic [7:0]  crate_id,
  input  wire logic [2:0]  time_bin,
  output cls_t             cls
);

  logic [7:0] addr;

  assign addr = word[23:16];

  always_comb begin
    cls.is_last    = last_word;
    cls.trailer_ok = (word == TRAILER_WORD);
    cls.crate_ok   = (word[31:24] == crate_id);
    // rebased index must also sit below the board count
    cls.addr_ok    = (addr[7:4] == ADDR_HIGH_NIB) &&
                     ({1'b0, addr[3:0]} < 5'(NUM_BOARDS));
    cls.board      = addr[3:0];
    cls.lines      = word[7:0];
    cls.chan       = word[31:27];
    cls.value      = word[11:0];
    cls.bin        = 3'(time_bin % NUM_TIME_BINS);
  end

endmodule
`default_nettype wire

// ===== sv/qrbd_back.sv =====
// Back end: holds group state and turns classified words into results.
`timescale 1ns / 1ps
`default_nettype none
module qrbd_back
  import qrbd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic go,
  input  wire cls_t cls,
  output res_t      res
);

  logic [7:0] lines_left_r, lines_left_nxt;
  logic [3:0] board_r, board_nxt;
  logic       skip_r, skip_nxt;

  always_comb begin
    lines_left_nxt = lines_left_r;
    board_nxt      = board_r;
    skip_nxt       = skip_r;
    res            = '0;
    if (cls.is_last) begin
      if (!cls.trailer_ok) begin
        res.status = ST_BAD_TRAILER;
      end else if (skip_r) begin
        res.status = ST_SKIP;
      end else if (lines_left_r != '0) begin
        res.status = ST_TRUNC;
      end else begin
        res.status = ST_TRAILER_OK;
      end
      lines_left_nxt = '0;
      skip_nxt       = 1'b0;
    end else if (skip_r) begin
      res.status = ST_SKIP;
    end else if (lines_left_r != '0) begin
      res.status      = ST_VALUE;
      res.board_index = board_r;
      res.channel     = cls.chan;
      res.bin_out     = cls.bin;
      res.value       = cls.value;
      lines_left_nxt  = lines_left_r - 1'b1;
    end else if (!cls.crate_ok) begin
      res.status = ST_CRATE;
      skip_nxt   = 1'b1;
    end else if (!cls.addr_ok) begin
      res.status = ST_ADDR;
      skip_nxt   = 1'b1;
    end else begin
      res.status      = ST_HEADER;
      res.board_index = cls.board;
      board_nxt       = cls.board;
      lines_left_nxt  = cls.lines;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lines_left_r <= '0;
      board_r      <= '0;
      skip_r       <= 1'b0;
    end else if (go) begin
      lines_left_r <= lines_left_nxt;
      board_r      <= board_nxt;
      skip_r       <= skip_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/qt_readout_block_decoder.sv =====
// Top level of the crate readout block decoder.
// Takes one 32-bit readout word per cycle while the input queue is not full, and gives one
// result item per word: header taken, channel value, trailer ok, or an error/skip status.
// Words are classified in the front end, wait in a QUEUE_DEPTH-entry queue, and are decoded
// by the back end into a QUEUE_DEPTH-entry result queue. Throughput is one item per cycle while
// results are popped; each word is registered in the mid queue, then in the result queue.
// After any error the rest of the block is reported as skipped up to its last word.
`timescale 1ns / 1ps
`default_nettype none
module qt_readout_block_decoder
  import qrbd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [31:0] in_word,
  input  wire logic        in_last_word,
  input  wire logic [7:0]  in_crate_id,
  input  wire logic [2:0]  in_time_bin,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [2:0]       out_status,
  output logic [3:0]       out_board_index,
  output logic [4:0]       out_channel,
  output logic [2:0]       out_bin_out,
  output logic [11:0]      out_value
);

  cls_t cls_in, cls_q;
  res_t res_d, res_q;
  logic mid_empty, out_full, go;

  qrbd_front u_front (
    .word      (in_word),
    .last_word (in_last_word),
    .crate_id  (in_crate_id),
    .time_bin  (in_time_bin),
    .cls       (cls_in)
  );

  qrbd_fifo #(.WIDTH($bits(cls_t)), .DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (cls_in),
    .full  (in_full),
    .pop   (go),
    .empty (mid_empty),
    .dout  (cls_q)
  );

  assign go = !mid_empty && !out_full;

  qrbd_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .cls   (cls_q),
    .res   (res_d)
  );

  qrbd_fifo #(.WIDTH($bits(res_t)), .DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (go),
    .din   (res_d),
    .full  (out_full),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (res_q)
  );

  assign out_status      = res_q.status;
  assign out_board_index = res_q.board_index;
  assign out_channel     = res_q.channel;
  assign out_bin_out     = res_q.bin_out;
  assign out_value       = res_q.value;

endmodule
`default_nettype wire

// ===== sv/qrbd_checker.sv =====
// Port-level checker for the readout block decoder, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module qrbd_checker
  import qrbd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [2:0]  out_status,
  input wire logic [3:0]  out_board_index,
  input wire logic [4:0]  out_channel,
  input wire logic [2:0]  out_bin_out,
  input wire logic [11:0] out_value
);

  // reset drains the result queue
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // only a channel value carries channel, bin and value
  a_value_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != ST_VALUE) |->
      (out_channel == '0 && out_bin_out == '0 && out_value == '0))
    else $error("payload fields set on a non-value item");

  // board index only on header and value items
  a_board_field: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != ST_VALUE && out_status != ST_HEADER) |->
      (out_board_index == '0))
    else $error("board index set on a status-only item");

  // a waiting item stays until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_status) && $stable(out_value)))
    else $error("waiting item changed or vanished");

endmodule

bind qt_readout_block_decoder qrbd_checker u_qrbd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_status      (out_status),
  .out_board_index (out_board_index),
  .out_channel     (out_channel),
  .out_bin_out     (out_bin_out),
  .out_value       (out_value)
);
`default_nettype wire
